FILE: design/byte_ring_buffer_peek_skip_unit_assert.svh
// Assertion macros for the byte ring buffer peek/skip unit
`ifndef BYTE_RING_BUFFER_PEEK_SKIP_UNIT_ASSERT_SVH
`define BYTE_RING_BUFFER_PEEK_SKIP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BRB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRB_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/brb_pkg.sv
// Shared constants, types and helpers of the byte ring buffer
`timescale 1ns / 1ps
package brb_pkg;
	localparam int DEPTH      = 1024;
	localparam int MAX_BURST  = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CAP_W      = 11;
	localparam int CNT_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int FUNC_W     = 3;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - CNT_W - CAP_W;
	localparam int IN_PAD_W    = IN_TDATA_W - BYTE_W - CNT_W;

	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
	localparam logic [CNT_W-1:0] BURST_MAX = CNT_W'(MAX_BURST);

	typedef enum logic [FUNC_W-1:0] {
		FN_WRITE  = 3'd0,
		FN_READ   = 3'd1,
		FN_PEEK   = 3'd2,
		FN_REMOVE = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} state_t;

	typedef struct packed {
		logic             cfg_we;
		logic             accept;
		logic             issue;
		logic             issue_last;
		logic [CNT_W-1:0] done;
	} cmd_t;

	typedef struct packed {
		logic             valid_s1;
		logic             out_free;
		logic             burst_start;
		logic [CNT_W-1:0] burst_n;
	} status_t;

	function automatic logic [ADDR_W-1:0] ring_adv(input logic [ADDR_W-1:0] pos,
			input logic [CNT_W-1:0] n, input logic [CAP_W-1:0] cap);
		logic [CAP_W:0] sum;
		sum = (CAP_W+1)'(pos) + (CAP_W+1)'(n);
		if (sum >= {1'b0, cap}) begin
			sum = sum - {1'b0, cap};
		end
		return sum[ADDR_W-1:0];
	endfunction
endpackage

FILE: design/byte_ring_buffer_peek_skip_unit.sv
// Top level of the byte ring buffer with peek and skip
//
//  channel | dir | handshake            | payload
//  s_*     | in  | s_tvalid / s_tready  | s_tuser func, s_tdata data_byte, count
//  m_*     | out | m_tvalid / m_tready  | m_tuser has_byte, m_tlast last, m_tdata rest
//  cfg_*   | in  | cfg_valid/cfg_ready  | cfg_data capacity
//
// Write, remove, clear and empty reads or peeks give one result word each.
// A read or peek of n bytes streams n words, one per cycle while the output is not
// stalled, paced by the single storage read port and its registered read stage.
// Reset clears pointers and fill level; capacity returns to 1024. No clearing pass.
// A stalled output holds the words in the output and read-stage registers.
`timescale 1ns / 1ps
`include "byte_ring_buffer_peek_skip_unit_assert.svh"
module byte_ring_buffer_peek_skip_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [brb_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte, [14:8] count
	input  logic [brb_pkg::FUNC_W-1:0]       s_tuser,  // [2:0] func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [brb_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [7:0] out_byte, [14:8] count_done,
	                                                    // [25:15] fill_level
	output logic                             m_tuser,  // [0] has_byte
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [brb_pkg::CAP_W-1:0]        cfg_data
);
	brb_pkg::cmd_t    cmd;
	brb_pkg::status_t st;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.cfg_valid (cfg_valid),
		.st        (st),
		.s_tready  (s_tready),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	brb_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cfg_data (cfg_data),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`BRB_ASSERT_NEXT(a_burst_blocks_input, s_tvalid && s_tready && st.burst_start, !s_tready, "input taken during burst")
	`BRB_ASSERT_IMPLY(a_fill_in_range, m_tvalid, m_tdata[25:15] <= brb_pkg::CAP_MAX, "fill level above depth")
	`BRB_ASSERT_IMPLY(a_burst_last_count, m_tvalid && m_tuser && m_tlast, m_tdata[14:8] != 7'd0, "burst end without count")
	`BRB_ASSERT_IMPLY(a_no_issue_when_idle, cmd.accept || cmd.cfg_we, !cmd.issue, "read issued while idle")
endmodule

FILE: design/brb_ctrl.sv
// Controller state machine: accepts words, sequences read and peek bursts
`timescale 1ns / 1ps
module brb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              cfg_valid,
	input  brb_pkg::status_t  st,
	output logic              s_tready,
	output logic              cfg_ready,
	output brb_pkg::cmd_t     cmd
);
	brb_pkg::state_t state_q, state_d;
	logic [brb_pkg::CNT_W-1:0] rem_q;
	logic [brb_pkg::CNT_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brb_pkg::ST_IDLE;
			rem_q   <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept && st.burst_start) begin
				rem_q   <= st.burst_n;
				total_q <= st.burst_n;
			end else if (cmd.issue) begin
				rem_q <= rem_q - brb_pkg::CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cfg_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			brb_pkg::ST_IDLE: begin
				cfg_ready  = !st.valid_s1;
				s_tready   = !st.valid_s1 && st.out_free && !cfg_valid;
				cmd.cfg_we = cfg_valid && !st.valid_s1;
				cmd.accept = s_tvalid && !st.valid_s1 && st.out_free && !cfg_valid;
				if (cmd.accept && st.burst_start) begin
					state_d = brb_pkg::ST_BURST;
				end
			end
			brb_pkg::ST_BURST: begin
				cmd.issue      = !st.valid_s1 || st.out_free;
				cmd.issue_last = (rem_q == brb_pkg::CNT_W'(1));
				cmd.done       = cmd.issue_last ? total_q : '0;
				if (cmd.issue && cmd.issue_last) begin
					state_d = brb_pkg::ST_IDLE;
				end
			end
			default: state_d = brb_pkg::ST_IDLE;
		endcase
	end
endmodule

FILE: design/brb_datapath.sv
// Datapath: storage, ring pointers, read stage and output register
`timescale 1ns / 1ps
module brb_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [brb_pkg::FUNC_W-1:0]        s_tuser,
	input  logic [brb_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [brb_pkg::CAP_W-1:0]         cfg_data,
	input  logic                              m_tready,
	input  brb_pkg::cmd_t                     cmd,
	output brb_pkg::status_t                  st,
	output logic                              m_tvalid,
	output logic [brb_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);
	logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];

	logic [brb_pkg::CAP_W-1:0]  capacity_q;
	logic [brb_pkg::ADDR_W-1:0] read_pos_q;
	logic [brb_pkg::ADDR_W-1:0] write_pos_q;
	logic [brb_pkg::ADDR_W-1:0] burst_pos_q;
	logic [brb_pkg::CAP_W-1:0]  held_q;

	logic                       valid_s1;
	logic [brb_pkg::BYTE_W-1:0] byte_s1;
	logic [brb_pkg::CNT_W-1:0]  done_s1;
	logic                       last_s1;

	logic                       out_valid_q;
	logic [brb_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_has_q;
	logic [brb_pkg::CNT_W-1:0]  out_done_q;
	logic                       out_last_q;
	logic [brb_pkg::CAP_W-1:0]  out_fill_q;

	brb_pkg::func_t             func;
	logic [brb_pkg::BYTE_W-1:0] data_byte;
	logic [brb_pkg::CNT_W-1:0]  count;
	logic [brb_pkg::CNT_W-1:0]  count_sat;
	logic [brb_pkg::CNT_W-1:0]  n;
	logic [brb_pkg::CAP_W-1:0]  cap_wr;
	logic                       room;
	logic                       out_free;
	logic                       s1_move;
	logic                       mem_we;
	logic                       single;
	logic                       do_clear;
	logic                       do_skip;
	logic [brb_pkg::CAP_W-1:0]  held_d;
	logic [brb_pkg::CNT_W-1:0]  single_done;

	assign func      = brb_pkg::func_t'(s_tuser);
	assign data_byte = s_tdata[brb_pkg::BYTE_W-1:0];
	assign count     = s_tdata[brb_pkg::BYTE_W +: brb_pkg::CNT_W];
	assign count_sat = (count > brb_pkg::BURST_MAX) ? brb_pkg::BURST_MAX : count;
	assign n         = (held_q < brb_pkg::CAP_W'(count_sat)) ? held_q[brb_pkg::CNT_W-1:0]
	                                                       : count_sat;
	assign room      = held_q < capacity_q;
	assign out_free  = !out_valid_q || m_tready;
	assign s1_move   = valid_s1 && out_free;

	always_comb begin
		if (cfg_data == '0) begin
			cap_wr = brb_pkg::CAP_W'(1);
		end else if (cfg_data > brb_pkg::CAP_MAX) begin
			cap_wr = brb_pkg::CAP_MAX;
		end else begin
			cap_wr = cfg_data;
		end
	end

	always_comb begin
		mem_we      = 1'b0;
		do_clear    = 1'b0;
		do_skip     = 1'b0;
		single      = 1'b1;
		held_d      = held_q;
		single_done = '0;
		unique case (func)
			brb_pkg::FN_WRITE: begin
				if (room) begin
					mem_we      = cmd.accept;
					held_d      = held_q + brb_pkg::CAP_W'(1);
					single_done = brb_pkg::CNT_W'(1);
				end
			end
			brb_pkg::FN_READ: begin
				single  = (n == '0);
				do_skip = 1'b1;
				held_d  = held_q - brb_pkg::CAP_W'(n);
			end
			brb_pkg::FN_PEEK: begin
				single = (n == '0);
			end
			brb_pkg::FN_REMOVE: begin
				do_skip     = 1'b1;
				held_d      = held_q - brb_pkg::CAP_W'(n);
				single_done = n;
			end
			brb_pkg::FN_CLEAR: begin
				do_clear = 1'b1;
				held_d   = '0;
			end
			default: begin
			end
		endcase
	end

	assign st.valid_s1    = valid_s1;
	assign st.out_free    = out_free;
	assign st.burst_start = !single;
	assign st.burst_n     = n;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[write_pos_q] <= data_byte;
		end
		if (cmd.issue) begin
			byte_s1 <= mem[burst_pos_q];
			done_s1 <= cmd.done;
			last_s1 <= cmd.issue_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= brb_pkg::CAP_MAX;
			read_pos_q  <= '0;
			write_pos_q <= '0;
			held_q      <= '0;
		end else if (cmd.cfg_we) begin
			capacity_q  <= cap_wr;
			read_pos_q  <= '0;
			write_pos_q <= '0;
			held_q      <= '0;
		end else if (cmd.accept) begin
			held_q <= held_d;
			if (do_clear) begin
				read_pos_q  <= '0;
				write_pos_q <= '0;
			end else if (do_skip) begin
				read_pos_q <= brb_pkg::ring_adv(read_pos_q, n, capacity_q);
			end
			if (mem_we) begin
				write_pos_q <= brb_pkg::ring_adv(write_pos_q, brb_pkg::CNT_W'(1),
				                                 capacity_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !single) begin
			burst_pos_q <= read_pos_q;
		end else if (cmd.issue) begin
			burst_pos_q <= brb_pkg::ring_adv(burst_pos_q, brb_pkg::CNT_W'(1), capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if ((cmd.accept && single) || s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && single) begin
			out_byte_q <= '0;
			out_has_q  <= 1'b0;
			out_done_q <= single_done;
			out_last_q <= 1'b1;
			out_fill_q <= held_d;
		end else if (s1_move) begin
			out_byte_q <= byte_s1;
			out_has_q  <= 1'b1;
			out_done_q <= done_s1;
			out_last_q <= last_s1;
			out_fill_q <= held_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{brb_pkg::OUT_PAD_W{1'b0}}, out_fill_q, out_done_q, out_byte_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

	logic unused_pad;
	assign unused_pad = ^s_tdata[brb_pkg::IN_TDATA_W-1 -: brb_pkg::IN_PAD_W];
	logic unused_sink_q;
	always_ff @(posedge clk) begin
		unused_sink_q <= unused_pad;
	end
endmodule
